@@ design/ofwsc_pkg.sv @@
// Shared types and constants for the object-follow wheel speed controller.
package ofwsc_pkg;

  localparam int COORD_BITS = 12;
  localparam int AREA_BITS  = 24;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int SPEED_W    = 32;

  localparam logic [0:0] OP_SAMPLE = 1'b0;
  localparam logic [0:0] OP_TICK   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_VELOCITY   = 3'd0,
    REG_WHEEL_DISTANCE = 3'd1,
    REG_TARGET_AREA    = 3'd2,
    REG_DEADBAND       = 3'd3,
    REG_DETECT_AREA    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [0:0]            op;
    logic [COORD_BITS-1:0] obj_x;
    logic [COORD_BITS-1:0] centre_x;
    logic [AREA_BITS-1:0]  obj_area;
  } in_item_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
  } out_item_t;

endpackage

@@ design/object_follow_wheel_speed_controller.sv @@
// Object-follow wheel speed controller: microcoded sequencer over a divider/multiplier datapath.
// A sample item gives no result. A tick while idle gives a zero result; a tracking tick
// runs the radix-16 divider three times (twice when both errors fall in the deadband).
// One item at a time; a new item is taken while a finished result waits in the output register.
// Reset (synchronous): idle, held sample cleared, registers at their documented defaults.
module object_follow_wheel_speed_controller (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ofwsc_pkg::in_item_t            in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ofwsc_pkg::out_item_t           out_data,
  input  logic                           cfg_we,
  input  logic [ofwsc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [ofwsc_pkg::CFG_W-1:0]    cfg_data
);
  import ofwsc_pkg::*;

  localparam int DVD_W    = 56;
  localparam int DSR_W    = 24;
  localparam int DIV_STEP = 4;
  localparam int DIV_ITER = DVD_W / DIV_STEP;
  localparam int CNT_W    = $clog2(DIV_ITER + 1);
  localparam int PROD_W   = 56;
  localparam int TH_W     = DVD_W + 1;
  localparam int LIN_W    = PROD_W + 3 - 16 + 1;
  localparam int SUM_W    = TH_W + 1;
  localparam int ERR_W    = (AREA_BITS > 24) ? AREA_BITS : 24;
  localparam int PC_W     = 4;

  localparam logic signed [SPEED_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SPEED_W-1:0] S32_MIN = 32'sh8000_0000;
  localparam logic [DVD_W-1:0] Q_LIM = DVD_W'(64'h8000_0000);

  typedef enum logic [3:0] {
    U_NOP, U_LD_TH, U_DIV, U_ST_TH, U_LD_D, U_ST_D, U_CHK, U_MUL_TH,
    U_LD_H, U_ST_H, U_MUL_D, U_ST_L, U_MIX, U_ZERO
  } uop_t;

  typedef enum logic [2:0] {
    C_NEXT, C_NO_TICK, C_IDLE, C_DIV_BUSY, C_BOTH_IN, C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    uop_t            uop;
    cond_t           cond;
    logic [PC_W-1:0] tgt;
    logic            last;
  } ctl_t;

  localparam logic [PC_W-1:0] PC_ZERO = 4'd15;

  function automatic ctl_t ucode(input logic [PC_W-1:0] pc_i);
    ctl_t c;
    case (pc_i)
      4'd0:    c = '{U_NOP,    C_NO_TICK,  4'd0,    1'b0};
      4'd1:    c = '{U_LD_TH,  C_IDLE,     PC_ZERO, 1'b0};
      4'd2:    c = '{U_DIV,    C_DIV_BUSY, 4'd2,    1'b0};
      4'd3:    c = '{U_ST_TH,  C_NEXT,     4'd0,    1'b0};
      4'd4:    c = '{U_LD_D,   C_NEXT,     4'd0,    1'b0};
      4'd5:    c = '{U_DIV,    C_DIV_BUSY, 4'd5,    1'b0};
      4'd6:    c = '{U_ST_D,   C_NEXT,     4'd0,    1'b0};
      4'd7:    c = '{U_CHK,    C_BOTH_IN,  PC_ZERO, 1'b0};
      4'd8:    c = '{U_MUL_TH, C_NEXT,     4'd0,    1'b0};
      4'd9:    c = '{U_LD_H,   C_NEXT,     4'd0,    1'b0};
      4'd10:   c = '{U_DIV,    C_DIV_BUSY, 4'd10,   1'b0};
      4'd11:   c = '{U_ST_H,   C_NEXT,     4'd0,    1'b0};
      4'd12:   c = '{U_MUL_D,  C_NEXT,     4'd0,    1'b0};
      4'd13:   c = '{U_ST_L,   C_NEXT,     4'd0,    1'b0};
      4'd14:   c = '{U_MIX,    C_OUT_BUSY, 4'd14,   1'b1};
      4'd15:   c = '{U_ZERO,   C_OUT_BUSY, PC_ZERO, 1'b1};
      default: c = '{U_NOP,    C_NEXT,     4'd0,    1'b1};
    endcase
    return c;
  endfunction

  function automatic logic signed [SPEED_W-1:0] sat_q(input logic [DVD_W-1:0] q,
                                                      input logic neg);
    logic signed [SPEED_W-1:0] r;
    if (neg) begin
      r = (q > Q_LIM) ? S32_MIN : -$signed(q[SPEED_W-1:0]);
    end else begin
      r = (q >= Q_LIM) ? S32_MAX : $signed(q[SPEED_W-1:0]);
    end
    return r;
  endfunction

  function automatic logic signed [SPEED_W-1:0] sat_sum(input logic signed [SUM_W-1:0] s);
    logic signed [SPEED_W-1:0] r;
    if (s > SUM_W'(S32_MAX)) begin
      r = S32_MAX;
    end else if (s < SUM_W'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = s[SPEED_W-1:0];
    end
    return r;
  endfunction

  // configuration and held sample
  logic [CFG_W-1:0]      max_velocity;
  logic [CFG_W-1:0]      wheel_distance;
  logic [CFG_W-1:0]      target_area;
  logic [15:0]           deadband;
  logic [CFG_W-1:0]      detect_area;
  logic                  idle_flag;
  logic [COORD_BITS-1:0] held_obj_x;
  logic [COORD_BITS-1:0] held_centre_x;
  logic [AREA_BITS-1:0]  held_area;

  // sequencer and datapath
  logic [PC_W-1:0]           pc;
  logic [PC_W-1:0]           pc_next;
  logic [DSR_W-1:0]          rem;
  logic [DVD_W-1:0]          dvd;
  logic [DSR_W-1:0]          dsr;
  logic [CNT_W-1:0]          cnt;
  logic                      div_neg;
  logic                      div_nz;
  logic                      div_dz;
  logic signed [SPEED_W-1:0] th_err;
  logic signed [SPEED_W-1:0] d_err;
  logic [PROD_W-1:0]         prod;
  logic signed [TH_W-1:0]    th_v;
  logic signed [LIN_W-1:0]   lin_v;

  ctl_t                  ctl;
  logic                  cond_hit;
  logic                  out_busy;
  logic [DSR_W-1:0]      rem_step;
  logic [DVD_W-1:0]      dvd_step;
  logic [SPEED_W-1:0]    th_mag;
  logic [SPEED_W-1:0]    d_mag;
  logic                  th_in;
  logic                  d_in;
  logic [COORD_BITS-1:0] hx_mag;
  logic [ERR_W-1:0]      area_ext;
  logic [ERR_W-1:0]      ta_ext;
  logic [ERR_W-1:0]      da_mag;
  logic [PROD_W+2:0]     p5;
  logic [SPEED_W-1:0]    mul_a;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_l;

  assign ctl      = ucode(pc);
  assign in_ready = (pc == '0);
  assign out_busy = out_valid && !out_ready;

  assign th_mag = th_err[SPEED_W-1] ? (~th_err + 1'b1) : th_err;
  assign d_mag  = d_err[SPEED_W-1] ? (~d_err + 1'b1) : d_err;
  assign th_in  = th_mag < {16'b0, deadband};
  assign d_in   = d_mag < {16'b0, deadband};

  assign hx_mag   = (held_centre_x >= held_obj_x) ? (held_centre_x - held_obj_x)
                                                  : (held_obj_x - held_centre_x);
  assign area_ext = ERR_W'(held_area);
  assign ta_ext   = ERR_W'(target_area);
  assign da_mag   = (ta_ext >= area_ext) ? (ta_ext - area_ext) : (area_ext - ta_ext);

  assign p5    = {prod, 2'b00} + (PROD_W+3)'(prod);
  assign mul_a = (ctl.uop == U_MUL_TH) ? th_mag : d_mag;
  assign sum_r = SUM_W'(th_v) + SUM_W'(lin_v);
  assign sum_l = SUM_W'(th_v) - SUM_W'(lin_v);

  always_comb begin
    logic [DSR_W:0]   t;
    logic [DSR_W-1:0] r;
    logic [DVD_W-1:0] d;
    r = rem;
    d = dvd;
    for (int i = 0; i < DIV_STEP; i++) begin
      t = {r, d[DVD_W-1]};
      d = {d[DVD_W-2:0], 1'b0};
      if (t >= {1'b0, dsr}) begin
        t    = t - {1'b0, dsr};
        d[0] = 1'b1;
      end
      r = t[DSR_W-1:0];
    end
    rem_step = r;
    dvd_step = d;
  end

  always_comb begin
    case (ctl.cond)
      C_NEXT:     cond_hit = 1'b0;
      C_NO_TICK:  cond_hit = !(in_valid && in_data.op == OP_TICK);
      C_IDLE:     cond_hit = idle_flag;
      C_DIV_BUSY: cond_hit = (cnt != CNT_W'(1));
      C_BOTH_IN:  cond_hit = th_in && d_in;
      C_OUT_BUSY: cond_hit = out_busy;
      default:    cond_hit = 1'b0;
    endcase
    if (cond_hit) begin
      pc_next = ctl.tgt;
    end else if (ctl.last) begin
      pc_next = '0;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc             <= '0;
      cnt            <= '0;
      out_valid      <= 1'b0;
      idle_flag      <= 1'b1;
      held_obj_x     <= '0;
      held_centre_x  <= '0;
      held_area      <= '0;
      max_velocity   <= CFG_W'(65536);
      wheel_distance <= CFG_W'(13107);
      target_area    <= CFG_W'(10000);
      deadband       <= 16'd6554;
      detect_area    <= CFG_W'(500);
    end else begin
      pc <= pc_next;

      if (cfg_we) begin
        case (cfg_addr)
          REG_MAX_VELOCITY:   max_velocity   <= cfg_data;
          REG_WHEEL_DISTANCE: wheel_distance <= cfg_data;
          REG_TARGET_AREA:    target_area    <= cfg_data;
          REG_DEADBAND:       deadband       <= cfg_data[15:0];
          REG_DETECT_AREA:    detect_area    <= cfg_data;
          default: ;
        endcase
      end

      if (in_valid && in_ready && in_data.op == OP_SAMPLE) begin
        if (ERR_W'(in_data.obj_area) > ERR_W'(detect_area)) begin
          idle_flag     <= 1'b0;
          held_obj_x    <= in_data.obj_x;
          held_centre_x <= in_data.centre_x;
          held_area     <= in_data.obj_area;
        end else begin
          idle_flag <= 1'b1;
        end
      end

      if (out_valid && out_ready && !(ctl.uop inside {U_MIX, U_ZERO})) begin
        out_valid <= 1'b0;
      end

      case (ctl.uop)
        U_LD_TH: begin
          dvd     <= DVD_W'({hx_mag, 16'b0});
          dsr     <= DSR_W'(held_centre_x);
          rem     <= '0;
          cnt     <= CNT_W'(DIV_ITER);
          div_neg <= held_obj_x > held_centre_x;
          div_nz  <= held_obj_x != held_centre_x;
          div_dz  <= held_centre_x == '0;
        end
        U_LD_D: begin
          dvd     <= DVD_W'({da_mag, 16'b0});
          dsr     <= target_area;
          rem     <= '0;
          cnt     <= CNT_W'(DIV_ITER);
          div_neg <= area_ext > ta_ext;
          div_nz  <= area_ext != ta_ext;
          div_dz  <= target_area == '0;
        end
        U_LD_H: begin
          dvd     <= {prod[DVD_W-2:0], 1'b0};
          dsr     <= wheel_distance;
          rem     <= '0;
          cnt     <= CNT_W'(DIV_ITER);
          div_neg <= th_err[SPEED_W-1];
          div_nz  <= prod != '0;
          div_dz  <= wheel_distance == '0;
        end
        U_DIV: begin
          if (cnt != '0) begin
            rem <= rem_step;
            dvd <= dvd_step;
            cnt <= cnt - 1'b1;
          end
        end
        U_ST_TH: begin
          if (div_dz) begin
            th_err <= div_nz ? (div_neg ? S32_MIN : S32_MAX) : '0;
          end else begin
            th_err <= sat_q(dvd, div_neg);
          end
        end
        U_ST_D: begin
          if (div_dz) begin
            d_err <= div_nz ? (div_neg ? S32_MIN : S32_MAX) : '0;
          end else begin
            d_err <= sat_q(dvd, div_neg);
          end
        end
        U_CHK: begin
          if (th_in && d_in) begin
            idle_flag <= 1'b1;
          end
        end
        U_MUL_TH, U_MUL_D: begin
          prod <= PROD_W'(mul_a) * PROD_W'(max_velocity);
        end
        U_ST_H: begin
          if (th_in) begin
            th_v <= '0;
          end else if (div_dz) begin
            th_v <= div_nz ? (div_neg ? TH_W'(S32_MIN) : TH_W'(S32_MAX)) : '0;
          end else begin
            th_v <= div_neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});
          end
        end
        U_ST_L: begin
          if (d_in) begin
            lin_v <= '0;
          end else begin
            lin_v <= d_err[SPEED_W-1] ? -$signed({1'b0, p5[PROD_W+2:16]})
                                      : $signed({1'b0, p5[PROD_W+2:16]});
          end
        end
        U_MIX: begin
          if (!out_busy) begin
            out_data.right_speed <= sat_sum(sum_r);
            out_data.left_speed  <= sat_sum(sum_l);
            out_valid            <= 1'b1;
          end
        end
        U_ZERO: begin
          if (!out_busy) begin
            out_data.right_speed <= '0;
            out_data.left_speed  <= '0;
            out_valid            <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ tb/sv/object_follow_wheel_speed_controller_tb.sv @@
// Self-checking testbench for the object-follow wheel speed controller: driver, monitor, predictor.
module object_follow_wheel_speed_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ofwsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0] cfg_data;

  object_follow_wheel_speed_controller DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  in_item_t pending_items[$];
  out_item_t expected_speeds[$];
  out_item_t head_speeds;
  int unsigned mismatches = 0;
  int unsigned cycle = 0;
  bit steady = 1'b0;

  // predictor state and register copies
  bit ctl_idle;
  logic [COORD_BITS-1:0] held_x, held_c;
  logic [AREA_BITS-1:0] held_area;
  logic [23:0] max_vel, wheel_dist, target_area, detect_area;
  logic [15:0] dead_band;

  function automatic longint sat32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint norm_error(longint num, longint den);
    if (den == 0) return (num > 0) ? S32_MAX : ((num < 0) ? S32_MIN : 64'sd0);
    return sat32(num * 65536 / den);
  endfunction

  function automatic void predict_wheel_speeds(in_item_t it);
    longint head_err, dist_err, head_v, lin_v, num;
    bit head_in, dist_in;
    out_item_t res;
    if (it.op == OP_SAMPLE) begin
      if (it.obj_area > detect_area) begin
        ctl_idle = 1'b0;
        held_x = it.obj_x;
        held_c = it.centre_x;
        held_area = it.obj_area;
      end else begin
        ctl_idle = 1'b1;
      end
      return;
    end
    res = '0;
    if (!ctl_idle) begin
      head_err = norm_error(longint'(held_c) - longint'(held_x), longint'(held_c));
      dist_err = norm_error(longint'(target_area) - longint'(held_area), longint'(target_area));
      head_in = ((head_err < 0) ? -head_err : head_err) < longint'(dead_band);
      dist_in = ((dist_err < 0) ? -dist_err : dist_err) < longint'(dead_band);
      if (head_in && dist_in) begin
        ctl_idle = 1'b1;
      end else begin
        head_v = 0;
        lin_v = 0;
        if (!head_in) begin
          num = 2 * head_err * longint'(max_vel);
          if (wheel_dist == 0) head_v = (num > 0) ? S32_MAX : ((num < 0) ? S32_MIN : 64'sd0);
          else head_v = num / longint'(wheel_dist);
        end
        if (!dist_in) lin_v = 5 * dist_err * longint'(max_vel) / 65536;
        res.right_speed = 32'(sat32(lin_v + head_v));
        res.left_speed = 32'(sat32(head_v - lin_v));
      end
    end
    expected_speeds.push_back(res);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR %0t %s: got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_wheel_speeds(in_data);
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 14)) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_speeds.size() == 0) begin
          report_mismatch("result with no tick pending", out_data.left_speed, '0);
        end else begin
          head_speeds = expected_speeds.pop_front();
          if (out_data.left_speed !== head_speeds.left_speed)
            report_mismatch("left_speed", out_data.left_speed, head_speeds.left_speed);
          if (out_data.right_speed !== head_speeds.right_speed)
            report_mismatch("right_speed", out_data.right_speed, head_speeds.right_speed);
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == CYCLE_LIMIT) begin
      $display("FAIL object_follow_wheel_speed_controller");
      $finish;
    end
  end

  task automatic push_sample(int x, int c, int a);
    in_item_t it;
    it.op = OP_SAMPLE;
    it.obj_x = COORD_BITS'(x);
    it.centre_x = COORD_BITS'(c);
    it.obj_area = AREA_BITS'(a);
    pending_items.push_back(it);
  endtask

  task automatic push_tick();
    in_item_t it;
    it.op = OP_TICK;
    it.obj_x = COORD_BITS'($urandom);
    it.centre_x = COORD_BITS'($urandom);
    it.obj_area = AREA_BITS'($urandom);
    pending_items.push_back(it);
  endtask

  task automatic wait_until_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_speeds.size() != 0);
    repeat (64) @(negedge clk);
  endtask

  task automatic load_registers(logic [23:0] mv, logic [23:0] wd, logic [23:0] ta,
                                logic [23:0] db, logic [23:0] da);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= REG_MAX_VELOCITY;
    cfg_data <= mv;
    max_vel = mv;
    @(posedge clk);
    cfg_addr <= REG_WHEEL_DISTANCE;
    cfg_data <= wd;
    wheel_dist = wd;
    @(posedge clk);
    cfg_addr <= REG_TARGET_AREA;
    cfg_data <= ta;
    target_area = ta;
    @(posedge clk);
    cfg_addr <= REG_DEADBAND;
    cfg_data <= db;
    dead_band = db[15:0];
    @(posedge clk);
    cfg_addr <= REG_DETECT_AREA;
    cfg_data <= da;
    detect_area = da;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // mostly sample-then-ticks sequences, with lone ticks and random noise
  task automatic queue_random_items(int n);
    int k, sel, nt, c, x, span;
    longint a, t, aspan;
    in_item_t it;
    k = 0;
    while (k < n) begin
      sel = $urandom_range(99);
      if (sel < 75) begin
        c = ($urandom_range(19) == 0) ? 0 : $urandom_range(4095);
        if ($urandom_range(1)) begin
          span = c / 8 + 1;
          x = c + $urandom_range(2 * span) - span;
          if (x < 0) x = 0;
          if (x > 4095) x = 4095;
        end else begin
          x = $urandom_range(4095);
        end
        t = longint'(target_area);
        sel = $urandom_range(99);
        if (sel < 40) begin
          aspan = t / 8 + 1;
          a = t + longint'($urandom_range(32'(2 * aspan))) - aspan;
          if (a < 0) a = 0;
          if (a > 24'hFFFFFF) a = 24'hFFFFFF;
        end else if (sel < 70) begin
          a = $urandom_range(24'hFFFFFF);
        end else if (sel < 85) begin
          a = longint'(detect_area) + $urandom_range(1);
          if (a > 24'hFFFFFF) a = 24'hFFFFFF;
        end else begin
          a = $urandom_range(32'(detect_area));
        end
        push_sample(x, c, int'(a));
        k++;
        nt = $urandom_range(1, 3);
        repeat (nt) push_tick();
        k += nt;
      end else if (sel < 90) begin
        push_tick();
        k++;
      end else begin
        it.op = 1'($urandom);
        it.obj_x = COORD_BITS'($urandom);
        it.centre_x = COORD_BITS'($urandom);
        it.obj_area = AREA_BITS'($urandom);
        pending_items.push_back(it);
        k++;
      end
    end
  endtask

  task automatic random_registers();
    logic [23:0] ta;
    ta = 24'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(12));
    if (ta == 0) ta = 1;
    load_registers(24'($urandom), 24'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(16)), ta,
                   24'($urandom), 24'($urandom_range(0, 32'(ta))));
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    ctl_idle = 1'b1;
    held_x = '0;
    held_c = '0;
    held_area = '0;
    max_vel = 24'd65536;
    wheel_dist = 24'd13107;
    target_area = 24'd10000;
    dead_band = 16'd6554;
    detect_area = 24'd500;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset register values
    push_tick();
    push_sample(2000, 2048, 0);
    push_tick();
    push_sample(0, 0, 24'hFFFFFF);
    push_tick();
    push_sample(4095, 0, 501);
    push_tick();
    push_sample(4095, 4095, 10000);
    push_tick();
    push_tick();
    push_sample(0, 4095, 501);
    push_tick();
    push_sample(2048, 2048, 600);
    push_tick();
    push_sample(1000, 2000, 20000);
    push_tick();
    push_tick();
    push_sample(1000, 2000, 500);
    push_tick();
    push_sample(1000, 2000, 501);
    push_sample(3000, 2000, 9000);
    push_tick();
    wait_until_drained();

    queue_random_items(160);
    wait_until_drained();

    // saturating extremes
    load_registers(24'hFFFFFF, 24'd1, 24'd1, 24'd0, 24'd0);
    push_sample(4095, 1, 24'hFFFFFF);
    push_tick();
    push_sample(0, 4095, 1);
    push_tick();
    push_sample(0, 0, 0);
    push_tick();
    queue_random_items(160);
    wait_until_drained();

    load_registers(24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFE);
    queue_random_items(60);
    wait_until_drained();

    random_registers();
    steady = 1'b1;
    queue_random_items(160);
    wait_until_drained();
    steady = 1'b0;

    random_registers();
    queue_random_items(160);
    wait_until_drained();

    if (mismatches == 0) begin
      $display("PASS object_follow_wheel_speed_controller");
    end else begin
      $display("FAIL object_follow_wheel_speed_controller");
    end
    $finish;
  end

endmodule
